// ===== hw/rtl/pnlb_pkg.sv =====
`default_nettype none
package pnlb_pkg;

    localparam int MAX_PIPES_DEF = 64;
    localparam int MAX_LOOPS = 16;
    localparam int FIFO_DEPTH = 4;

    localparam logic [63:0] K_NUM = 64'd8000000000000000;
    localparam logic [26:0] K_DEN = 27'd96787756;

    localparam logic [1:0] CFG_LOOP_COUNT = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER = 2'd2;

    typedef struct packed {
        logic [63:0] k;
        logic [31:0] flow;
        logic [3:0]  loop_id;
        logic        sign;
    } pnlb_entry_t;

    typedef struct packed {
        pnlb_entry_t entry;
        logic        last;
    } pnlb_item_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_MWAIT, F_DIV, F_DWAIT, F_PUSH
    } pnlb_fstate_t;

    typedef enum logic [2:0] {
        OP_FL, OP_NUM, OP_D2, OP_D4, OP_D5, OP_DEN
    } pnlb_op_t;

    typedef enum logic [4:0] {
        B_LOAD, B_START, B_SWEEP, B_LOOP, B_SCAN_RD, B_SCAN_CHK, B_MUL_T,
        B_MUL_TERM, B_DIV, B_DIV_WAIT, B_UPD_RD, B_UPD_CHK, B_LOOP_NEXT,
        B_SWEEP_END, B_EM_RD, B_EM_START, B_EM_MUL1, B_EM_MUL2, B_EM_OUT
    } pnlb_bstate_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pnlb_mul.sv =====
`default_nettype none
module pnlb_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [95:0]  a,
    input  logic [31:0]  b,
    output logic         done,
    output logic [127:0] prod
);
    logic [95:0]  a_reg;
    logic [31:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  digit;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // Three 32-bit digits of a, one per cycle.
    always_comb
    begin
        case (step_reg)
            2'd0:    digit = a_reg[31:0];
            2'd1:    digit = a_reg[63:32];
            default: digit = a_reg[95:64];
        endcase
    end

    assign pp = {32'b0, digit} * {32'b0, b_reg};

    always_comb
    begin
        case (step_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            default: pp_sh = {pp, 64'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= 2'd0;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pnlb_div.sv =====
`default_nettype none
module pnlb_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [127:0] den,
    output logic         done,
    output logic [127:0] quo
);
    logic [127:0] r_reg;
    logic [127:0] q_reg;
    logic [127:0] n_reg;
    logic [127:0] d_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [128:0] rs;
    logic         fits;

    assign rs = {r_reg, n_reg[127]};
    assign fits = rs >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle, MSB first.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            r_reg <= '0;
            q_reg <= '0;
            n_reg <= num;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= fits ? 128'(rs - {1'b0, d_reg}) : rs[127:0];
            q_reg <= {q_reg[126:0], fits};
            n_reg <= {n_reg[126:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quo = q_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pnlb_fifo.sv =====
`default_nettype none
module pnlb_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pnlb_pkg::pnlb_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output pnlb_pkg::pnlb_item_t pop_item,
    output logic                 not_empty
);
    import pnlb_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    pnlb_item_t       slots [FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full = count_reg == (PW+1)'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;
    assign pop_item = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pnlb_front.sv =====
`default_nettype none
module pnlb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [11:0]          pipe_diameter,
    input  logic [15:0]          pipe_length,
    input  logic [15:0]          friction_factor,
    input  logic signed [31:0]   initial_flow,
    input  logic [3:0]           loop_number,
    input  logic                 counter_clockwise,
    input  logic                 last_pipe,
    output logic                 push,
    output pnlb_pkg::pnlb_item_t push_item,
    input  logic                 full
);
    import pnlb_pkg::*;

    pnlb_fstate_t state_reg, state_next;
    pnlb_op_t     op_reg, op_next;

    logic [11:0]  d_reg;
    logic [15:0]  l_reg;
    logic [15:0]  f_reg;
    logic [31:0]  flow_reg;
    logic [3:0]   loop_reg;
    logic         sign_reg;
    logic         last_reg;
    logic [31:0]  fl_reg;
    logic [127:0] num_reg;
    logic [23:0]  d2_reg;
    logic [47:0]  d4_reg;
    logic [59:0]  d5_reg;
    logic [127:0] den_reg;
    logic [63:0]  k_reg;

    logic         mul_start;
    logic [95:0]  mul_a;
    logic [31:0]  mul_b;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         div_start;
    logic         div_done;
    logic [127:0] div_quo;
    logic         accept;

    pnlb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pnlb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign accept = in_valid && in_ready;

    always_comb
    begin
        unique case (op_reg)
            OP_FL:
            begin
                mul_a = {80'b0, f_reg};
                mul_b = {16'b0, l_reg};
            end
            OP_NUM:
            begin
                mul_a = {32'b0, K_NUM};
                mul_b = fl_reg;
            end
            OP_D2:
            begin
                mul_a = {84'b0, d_reg};
                mul_b = {20'b0, d_reg};
            end
            OP_D4:
            begin
                mul_a = {72'b0, d2_reg};
                mul_b = {8'b0, d2_reg};
            end
            OP_D5:
            begin
                mul_a = {48'b0, d4_reg};
                mul_b = {20'b0, d_reg};
            end
            OP_DEN:
            begin
                mul_a = {36'b0, d5_reg};
                mul_b = {5'b0, K_DEN};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        in_ready = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        push = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next = OP_FL;
                    state_next = (pipe_diameter == '0) ? F_PUSH : F_MUL;
                end
            end
            F_MUL:
            begin
                mul_start = 1'b1;
                state_next = F_MWAIT;
            end
            F_MWAIT:
            begin
                if (mul_done)
                begin
                    unique case (op_reg)
                        OP_FL:   op_next = OP_NUM;
                        OP_NUM:  op_next = OP_D2;
                        OP_D2:   op_next = OP_D4;
                        OP_D4:   op_next = OP_D5;
                        OP_D5:   op_next = OP_DEN;
                        default: op_next = OP_DEN;
                    endcase
                    state_next = (op_reg == OP_DEN) ? F_DIV : F_MUL;
                end
            end
            F_DIV:
            begin
                div_start = 1'b1;
                state_next = F_DWAIT;
            end
            F_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push = 1'b1;
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            op_reg    <= OP_FL;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg    <= pipe_diameter;
            l_reg    <= pipe_length;
            f_reg    <= friction_factor;
            flow_reg <= initial_flow;
            loop_reg <= loop_number;
            sign_reg <= counter_clockwise;
            last_reg <= last_pipe;
            k_reg    <= '1;
        end
        if (state_reg == F_MWAIT && mul_done)
        begin
            unique case (op_reg)
                OP_FL:   fl_reg  <= mul_prod[31:0];
                OP_NUM:  num_reg <= {mul_prod[95:0], 32'b0};
                OP_D2:   d2_reg  <= mul_prod[23:0];
                OP_D4:   d4_reg  <= mul_prod[47:0];
                OP_D5:   d5_reg  <= mul_prod[59:0];
                default: den_reg <= mul_prod;
            endcase
        end
        if (state_reg == F_DWAIT && div_done)
        begin
            k_reg <= (div_quo[127:64] != '0) ? '1 : div_quo[63:0];
        end
    end

    assign push_item.entry.k = k_reg;
    assign push_item.entry.flow = flow_reg;
    assign push_item.entry.loop_id = loop_reg;
    assign push_item.entry.sign = sign_reg;
    assign push_item.last = last_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pnlb_back.sv =====
`default_nettype none
module pnlb_back #(
    parameter int MAX_PIPES = pnlb_pkg::MAX_PIPES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 q_valid,
    input  pnlb_pkg::pnlb_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [5:0]           pipe_number,
    output logic signed [31:0]   final_flow,
    output logic signed [47:0]   head_loss,
    output logic [15:0]          iterations_used,
    output logic [31:0]          max_correction,
    output logic                 converged,
    output logic                 last_result
);
    import pnlb_pkg::*;

    localparam int AW = $clog2(MAX_PIPES);
    localparam int CW = $clog2(MAX_PIPES + 1);

    pnlb_entry_t mem [MAX_PIPES];
    pnlb_entry_t rdata_reg;

    pnlb_bstate_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [4:0]    lp_reg, lp_next;
    logic [15:0]   iters_reg, iters_next;
    logic [31:0]   maxc_reg, maxc_next;
    logic          conv_reg, conv_next;
    logic [127:0]  num_reg, num_next;
    logic [127:0]  den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [63:0]   q_reg, q_next;
    logic          ov_reg, ov_next;
    logic [5:0]    pn_reg, pn_next;
    logic [31:0]   ff_reg, ff_next;
    logic [47:0]   hl_reg, hl_next;
    logic          lr_reg, lr_next;

    logic [4:0]    loop_count_reg;
    logic [31:0]   tol_reg;
    logic [15:0]   maxit_reg;
    logic [4:0]    lim;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    pnlb_entry_t   mem_wdata;

    logic          mul_start;
    logic [95:0]   mul_a;
    logic [31:0]   mul_b;
    logic          mul_done;
    logic [127:0]  mul_prod;
    logic          div_start;
    logic [127:0]  div_num;
    logic          div_done;
    logic [127:0]  div_quo;

    logic [31:0]   aq;
    logic          member;
    logic [127:0]  term;
    logic signed [65:0] upd_sum;
    logic [63:0]   h;

    pnlb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pnlb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({den_reg[126:0], 1'b0}),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign lim = (loop_count_reg < 5'(MAX_LOOPS)) ? loop_count_reg : 5'(MAX_LOOPS);
    assign aq = rdata_reg.flow[31] ? 32'(~rdata_reg.flow + 32'd1) : rdata_reg.flow;
    assign member = {1'b0, rdata_reg.loop_id} == lp_reg;
    assign term = (rdata_reg.flow[31] != rdata_reg.sign) ? 128'(~mul_prod + 128'd1)
                                                         : mul_prod;
    assign div_num = num_reg[127] ? 128'(~num_reg + 128'd1) : num_reg;
    // Pipes on the loop's own sense move with the correction, the others against it.
    assign upd_sum = ((neg_reg ^ rdata_reg.sign)
                     ? 66'($signed(rdata_reg.flow)) + $signed({2'b0, q_reg})
                     : 66'($signed(rdata_reg.flow)) - $signed({2'b0, q_reg}));
    assign h = mul_prod[127:64];

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        lp_next = lp_reg;
        iters_next = iters_reg;
        maxc_next = maxc_reg;
        conv_next = conv_reg;
        num_next = num_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        q_next = q_reg;
        ov_next = ov_reg;
        pn_next = pn_reg;
        ff_next = ff_reg;
        hl_next = hl_reg;
        lr_next = lr_reg;
        q_pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        mem_we = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = q_item.entry;
        mul_start = 1'b0;
        mul_a = {32'b0, rdata_reg.k};
        mul_b = aq;
        div_start = 1'b0;
        unique case (state_reg)
            B_LOAD:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    // Records past a full table are dropped.
                    if (cnt_reg < CW'(MAX_PIPES))
                    begin
                        mem_we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (q_item.last)
                    begin
                        state_next = B_START;
                    end
                end
            end
            B_START:
            begin
                iters_next = '0;
                conv_next = 1'b0;
                maxc_next = '0;
                idx_next = '0;
                state_next = (maxit_reg == '0) ? B_EM_RD : B_SWEEP;
            end
            B_SWEEP:
            begin
                maxc_next = '0;
                lp_next = '0;
                state_next = (lim == '0) ? B_SWEEP_END : B_LOOP;
            end
            B_LOOP:
            begin
                num_next = '0;
                den_next = '0;
                idx_next = '0;
                state_next = B_SCAN_RD;
            end
            B_SCAN_RD:
            begin
                rd_en = 1'b1;
                state_next = B_SCAN_CHK;
            end
            B_SCAN_CHK:
            begin
                if (member)
                begin
                    mul_start = 1'b1;
                    state_next = B_MUL_T;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == cnt_reg) ? B_DIV : B_SCAN_RD;
                end
            end
            B_MUL_T:
            begin
                mul_a = {16'b0, mul_prod[95:16]};
                if (mul_done)
                begin
                    den_next = den_reg + {48'b0, mul_prod[95:16]};
                    mul_start = 1'b1;
                    state_next = B_MUL_TERM;
                end
            end
            B_MUL_TERM:
            begin
                if (mul_done)
                begin
                    num_next = num_reg + term;
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == cnt_reg) ? B_DIV : B_SCAN_RD;
                end
            end
            B_DIV:
            begin
                if (den_reg == '0)
                begin
                    state_next = B_LOOP_NEXT;
                end
                else
                begin
                    div_start = 1'b1;
                    neg_next = num_reg[127];
                    state_next = B_DIV_WAIT;
                end
            end
            B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    q_next = div_quo[63:0];
                    if (div_quo[63:0] > {32'b0, maxc_reg})
                    begin
                        maxc_next = div_quo[31:0];
                    end
                    idx_next = '0;
                    state_next = B_UPD_RD;
                end
            end
            B_UPD_RD:
            begin
                rd_en = 1'b1;
                state_next = B_UPD_CHK;
            end
            B_UPD_CHK:
            begin
                if (member)
                begin
                    mem_we = 1'b1;
                    mem_waddr = idx_reg[AW-1:0];
                    mem_wdata = rdata_reg;
                    if (upd_sum > 66'sd2147483647)
                    begin
                        mem_wdata.flow = 32'h7FFFFFFF;
                    end
                    else if (upd_sum < -66'sd2147483648)
                    begin
                        mem_wdata.flow = 32'h80000000;
                    end
                    else
                    begin
                        mem_wdata.flow = upd_sum[31:0];
                    end
                end
                idx_next = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == cnt_reg) ? B_LOOP_NEXT : B_UPD_RD;
            end
            B_LOOP_NEXT:
            begin
                lp_next = lp_reg + 5'd1;
                state_next = (lp_reg + 5'd1 == lim) ? B_SWEEP_END : B_LOOP;
            end
            B_SWEEP_END:
            begin
                iters_next = iters_reg + 16'd1;
                idx_next = '0;
                if (maxc_reg < tol_reg)
                begin
                    conv_next = 1'b1;
                    state_next = B_EM_RD;
                end
                else if ({1'b0, iters_reg} + 17'd1 < {1'b0, maxit_reg})
                begin
                    state_next = B_SWEEP;
                end
                else
                begin
                    state_next = B_EM_RD;
                end
            end
            B_EM_RD:
            begin
                rd_en = 1'b1;
                state_next = B_EM_START;
            end
            B_EM_START:
            begin
                mul_start = 1'b1;
                state_next = B_EM_MUL1;
            end
            B_EM_MUL1:
            begin
                mul_a = mul_prod[95:0];
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    state_next = B_EM_MUL2;
                end
            end
            B_EM_MUL2:
            begin
                if (mul_done)
                begin
                    if (rdata_reg.flow[31])
                    begin
                        hl_next = (h > 64'h800000000000) ? 48'h800000000000
                                                         : 48'(~h + 64'd1);
                    end
                    else
                    begin
                        hl_next = (h > 64'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : h[47:0];
                    end
                    pn_next = 6'(idx_reg);
                    ff_next = rdata_reg.flow;
                    lr_next = idx_reg + 1'b1 == cnt_reg;
                    ov_next = 1'b1;
                    state_next = B_EM_OUT;
                end
            end
            B_EM_OUT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    idx_next = idx_reg + 1'b1;
                    if (lr_reg)
                    begin
                        cnt_next = '0;
                        state_next = B_LOAD;
                    end
                    else
                    begin
                        state_next = B_EM_RD;
                    end
                end
            end
            default: state_next = B_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_LOAD;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            lp_reg         <= '0;
            iters_reg      <= '0;
            maxc_reg       <= '0;
            conv_reg       <= 1'b0;
            ov_reg         <= 1'b0;
            loop_count_reg <= 5'd1;
            tol_reg        <= 32'd66;
            maxit_reg      <= 16'd100;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            lp_reg    <= lp_next;
            iters_reg <= iters_next;
            maxc_reg  <= maxc_next;
            conv_reg  <= conv_next;
            ov_reg    <= ov_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LOOP_COUNT: loop_count_reg <= cfg_data[4:0];
                    CFG_TOLERANCE:  tol_reg <= cfg_data;
                    CFG_MAX_ITER:   maxit_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
        pn_reg  <= pn_next;
        ff_reg  <= ff_next;
        hl_reg  <= hl_next;
        lr_reg  <= lr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_valid = ov_reg;
    assign pipe_number = pn_reg;
    assign final_flow = ff_reg;
    assign head_loss = hl_reg;
    assign iterations_used = iters_reg;
    assign max_correction = maxc_reg;
    assign converged = conv_reg;
    assign last_result = lr_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pipe_network_loop_balancer.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    one pipe record
// out       output     out_valid / out_ready  one pipe result
// cfg       input      cfg_write              cfg_index, cfg_data
//
// The front takes a new record only once the last is pushed: six multiplies
// and a resistance divide (both skipped at zero diameter), then a push into
// a four-entry queue. After the last record each loop of a sweep scans the
// table through its single read port, runs the correction divider unless its
// denominator is zero, and updates its pipes. Results then wait on out_ready.
// Reset empties the table and restores the register defaults.
`default_nettype none
module pipe_network_loop_balancer #(
    parameter int MAX_PIPES = pnlb_pkg::MAX_PIPES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        pipe_diameter,
    input  logic [15:0]        pipe_length,
    input  logic [15:0]        friction_factor,
    input  logic signed [31:0] initial_flow,
    input  logic [3:0]         loop_number,
    input  logic               counter_clockwise,
    input  logic               last_pipe,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         pipe_number,
    output logic signed [31:0] final_flow,
    output logic signed [47:0] head_loss,
    output logic [15:0]        iterations_used,
    output logic [31:0]        max_correction,
    output logic               converged,
    output logic               last_result
);
    import pnlb_pkg::*;

    logic       push;
    pnlb_item_t push_item;
    logic       full;
    logic       pop;
    pnlb_item_t pop_item;
    logic       not_empty;

    pnlb_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pipe_diameter     (pipe_diameter),
        .pipe_length       (pipe_length),
        .friction_factor   (friction_factor),
        .initial_flow      (initial_flow),
        .loop_number       (loop_number),
        .counter_clockwise (counter_clockwise),
        .last_pipe         (last_pipe),
        .push              (push),
        .push_item         (push_item),
        .full              (full)
    );

    pnlb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );

    pnlb_back #(
        .MAX_PIPES (MAX_PIPES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_valid         (not_empty),
        .q_item          (pop_item),
        .q_pop           (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pipe_number     (pipe_number),
        .final_flow      (final_flow),
        .head_loss       (head_loss),
        .iterations_used (iterations_used),
        .max_correction  (max_correction),
        .converged       (converged),
        .last_result     (last_result)
    );
endmodule
`default_nettype wire
